// ----- hw/rtl/ped_pkg.sv -----
`default_nettype none

package ped_pkg;

  localparam logic [7:0] CharPercent    = 8'h25;
  localparam logic [7:0] CharUnderscore = 8'h5f;
  localparam logic [4:0] HexNone        = 5'h10;

  localparam logic [2:0] StatusOk           = 3'd0;
  localparam logic [2:0] StatusNotPermitted = 3'd1;
  localparam logic [2:0] StatusHexExpected  = 3'd2;
  localparam logic [2:0] StatusOpenAtEnd    = 3'd3;
  localparam logic [2:0] StatusDropped      = 3'd4;

  typedef enum logic [1:0] {
    PHASE_PLAIN = 2'd0,
    PHASE_HIGH  = 2'd1,
    PHASE_LOW   = 2'd2
  } ped_phase_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } ped_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic [2:0] out_status;
    logic       out_end;
  } ped_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/percent_escape_decoder.sv -----
// Percent-escape decoder: one character per transfer in, one result per transfer out.
// Letters, digits and underscore pass through, '%' followed by two hex digits yields
// one byte, and anything else marks an error that drops the rest of the string; all
// state clears after the character flagged as last. A character is taken in every
// cycle, and its result appears in the output register in the next cycle; the only
// thing that holds off input is that register still being full and stalled.
`default_nettype none

module percent_escape_decoder import ped_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ped_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output ped_out_t      out_data_o
);

  logic     accept;
  logic     busy;
  ped_out_t result;

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  ped_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .result_o (result)
  );

  ped_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .data_i  (result),
    .busy_o  (busy),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ped_step.sv -----
`default_nettype none

module ped_step import ped_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire ped_in_t  item_i,
  output ped_out_t      result_o
);

  ped_phase_e phase_q, phase_d;
  logic [3:0] nibble_q, nibble_d;
  logic       err_q, err_d;
  logic [4:0] hex;
  logic [7:0] c;
  logic       permitted;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = HexNone;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      v = {1'b0, ch[3:0] + 4'd9};
    end
    return v;
  endfunction

  assign c   = item_i.in_char;
  assign hex = hex_value(c);
  assign permitted = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
                     (c >= 8'h41 && c <= 8'h5a) || (c == CharUnderscore);

  always_comb begin
    phase_d  = phase_q;
    nibble_d = nibble_q;
    err_d    = err_q;
    result_o.out_byte     = 8'd0;
    result_o.out_has_byte = 1'b0;
    result_o.out_status   = StatusOk;
    result_o.out_end      = item_i.in_last;
    priority if (err_q) begin
      result_o.out_status = StatusDropped;
    end else if (phase_q == PHASE_HIGH || phase_q == PHASE_LOW) begin
      priority if (hex[4]) begin
        result_o.out_status = StatusHexExpected;
        err_d   = 1'b1;
        phase_d = PHASE_PLAIN;
      end else if (phase_q == PHASE_HIGH) begin
        nibble_d = hex[3:0];
        phase_d  = PHASE_LOW;
      end else begin
        result_o.out_byte     = {nibble_q, hex[3:0]};
        result_o.out_has_byte = 1'b1;
        phase_d = PHASE_PLAIN;
      end
    end else begin
      phase_d = PHASE_PLAIN;
      priority if (c == CharPercent) begin
        phase_d = PHASE_HIGH;
      end else if (permitted) begin
        result_o.out_byte     = c;
        result_o.out_has_byte = 1'b1;
      end else begin
        result_o.out_status = StatusNotPermitted;
        err_d = 1'b1;
      end
    end
    if (item_i.in_last) begin
      if (result_o.out_status == StatusOk && phase_d != PHASE_PLAIN) begin
        result_o.out_status = StatusOpenAtEnd;
      end
      phase_d  = PHASE_PLAIN;
      nibble_d = 4'd0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_PLAIN;
      nibble_q <= 4'd0;
      err_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      nibble_q <= nibble_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ped_out_reg.sv -----
`default_nettype none

module ped_out_reg import ped_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire ped_out_t data_i,
  output logic          busy_o,
  output logic          valid_o,
  input  wire logic     stall_i,
  output ped_out_t      data_o
);

  logic     valid_q, valid_d;
  ped_out_t data_q;

  assign busy_o  = valid_q & stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_percent_escape_decoder.sv -----
`timescale 1ns / 1ps

module tb_percent_escape_decoder;
  import ped_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ItemsPerPhase = 250;

  localparam int StrClean  = 0;
  localparam int StrBroken = 1;
  localparam int StrNoise  = 2;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  ped_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ped_out_t out_data_o;

  ped_in_t  pending_chars[$];
  ped_out_t expected_results[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int failures = 0;
  int chars_sent = 0;
  int results_checked = 0;
  int bytes_decoded = 0;
  int errors_flagged = 0;
  int open_ends = 0;
  int dropped_chars = 0;

  ped_phase_e dec_phase = PHASE_PLAIN;
  logic [3:0] dec_high = 4'h0;
  logic       dec_err = 1'b0;

  percent_escape_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    return HexNone;
  endfunction

  function automatic logic is_plain(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == CharUnderscore;
  endfunction

  task automatic predict_result(input ped_in_t it);
    ped_out_t   r;
    logic [4:0] nib;
    r = '0;
    r.out_status = StatusOk;
    r.out_end = it.in_last;
    if (dec_err) begin
      r.out_status = StatusDropped;
    end else if (dec_phase == PHASE_HIGH || dec_phase == PHASE_LOW) begin
      nib = hex_nibble(it.in_char);
      if (nib == HexNone) begin
        r.out_status = StatusHexExpected;
        dec_err = 1'b1;
        dec_phase = PHASE_PLAIN;
      end else if (dec_phase == PHASE_HIGH) begin
        dec_high = nib[3:0];
        dec_phase = PHASE_LOW;
      end else begin
        r.out_byte = {dec_high, nib[3:0]};
        r.out_has_byte = 1'b1;
        dec_phase = PHASE_PLAIN;
      end
    end else begin
      dec_phase = PHASE_PLAIN;
      if (it.in_char == CharPercent) begin
        dec_phase = PHASE_HIGH;
      end else if (is_plain(it.in_char)) begin
        r.out_byte = it.in_char;
        r.out_has_byte = 1'b1;
      end else begin
        r.out_status = StatusNotPermitted;
        dec_err = 1'b1;
      end
    end
    if (it.in_last) begin
      if (r.out_status == StatusOk && dec_phase != PHASE_PLAIN) r.out_status = StatusOpenAtEnd;
      dec_phase = PHASE_PLAIN;
      dec_high = 4'h0;
      dec_err = 1'b0;
    end
    if (r.out_has_byte) bytes_decoded++;
    if (r.out_status == StatusNotPermitted || r.out_status == StatusHexExpected) errors_flagged++;
    if (r.out_status == StatusOpenAtEnd) open_ends++;
    if (r.out_status == StatusDropped) dropped_chars++;
    expected_results.push_back(r);
  endtask

  function automatic logic [7:0] rand_plain();
    case ($urandom_range(3))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return CharUnderscore;
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(2))
      0: return 8'("0" + $urandom_range(9));
      1: return 8'("a" + $urandom_range(5));
      default: return 8'("A" + $urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_nibble(c) != HexNone);
    return c;
  endfunction

  function automatic logic [7:0] rand_forbidden();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_plain(c) || c == CharPercent);
    return c;
  endfunction

  task automatic queue_text(input logic [7:0] text[$]);
    ped_in_t it;
    foreach (text[i]) begin
      it.in_char = text[i];
      it.in_last = (i == text.size() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic queue_string(input int kind, output int n);
    logic [7:0] text[$];
    int         tokens;
    int         pos;
    logic [7:0] bad;
    tokens = $urandom_range(1, 6);
    if (kind == StrNoise) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(255)));
    end else begin
      repeat (tokens) begin
        if ($urandom_range(2) == 0) begin
          text.push_back(CharPercent);
          text.push_back(rand_hex());
          text.push_back(rand_hex());
        end else begin
          text.push_back(rand_plain());
        end
      end
    end
    if (kind == StrBroken) begin
      case ($urandom_range(3))
        0: text.push_back(CharPercent);
        1: begin
          text.push_back(CharPercent);
          text.push_back(rand_hex());
        end
        2: begin
          text.push_back(CharPercent);
          if ($urandom_range(1)) text.push_back(rand_hex());
          text.push_back(rand_non_hex());
          repeat ($urandom_range(3)) text.push_back(8'($urandom_range(255)));
        end
        default: begin
          bad = rand_forbidden();
          pos = $urandom_range(text.size());
          text.insert(pos, bad);
        end
      endcase
    end
    queue_text(text);
    n = text.size();
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_result(in_data_i);
        chars_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_chars.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    ped_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: %p", out_data_o);
          failures++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_data_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, out_data_o.out_byte);
            failures++;
          end
          if (out_data_o.out_has_byte !== want.out_has_byte) begin
            $error("out_has_byte: expected %0b, actual %0b", want.out_has_byte,
                   out_data_o.out_has_byte);
            failures++;
          end
          if (out_data_o.out_status !== want.out_status) begin
            $error("out_status: expected %0d, actual %0d", want.out_status,
                   out_data_o.out_status);
            failures++;
          end
          if (out_data_o.out_end !== want.out_end) begin
            $error("out_end: expected %0b, actual %0b", want.out_end, out_data_o.out_end);
            failures++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[percent_escape_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    int         idle_tab[4];
    int         stall_tab[4];
    int         added;
    int         n;
    int         roll;
    logic [7:0] text[$];
    idle_tab = '{0, 67, 0, 18};
    stall_tab = '{0, 0, 67, 18};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    text = '{"a", "z", "A", "Z", "0", "9", CharUnderscore};
    queue_text(text);
    text = '{CharPercent, "0", "0", CharPercent, "f", "f", CharPercent, "F", "F"};
    queue_text(text);
    text = '{CharPercent};
    queue_text(text);
    text = '{CharPercent, "4"};
    queue_text(text);
    text = '{8'h00, 8'hff};
    queue_text(text);
    text = '{CharPercent, "g"};
    queue_text(text);
    text = '{CharPercent, "1", "G"};
    queue_text(text);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      added = 0;
      while (added < ItemsPerPhase) begin
        roll = $urandom_range(99);
        queue_string(roll < 70 ? StrClean : (roll < 85 ? StrBroken : StrNoise), n);
        added += n;
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (10) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      failures++;
    end
    $display("%0d characters in, %0d results checked: %0d decoded bytes, %0d errors,",
             chars_sent, results_checked, bytes_decoded, errors_flagged);
    $display("%0d open escapes at end, %0d characters dropped", open_ends, dropped_chars);
    if (failures == 0) begin
      $display("[percent_escape_decoder] OK");
    end else begin
      $display("[percent_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule
